// File: rtl/core/mtar_pkg.sv
package mtar_pkg;

    // Display modes
    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_INTENSE  = 2'd1;
    localparam logic [1:0] MODE_BLINK    = 2'd2;
    localparam logic [1:0] MODE_GRAPHICS = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NINE_DOT     = 1'd1;

    // Item kinds
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_VSYNC = 1'b1;

    // Palette indices
    localparam logic [1:0] PAL_BLACK  = 2'd0;
    localparam logic [1:0] PAL_DIM    = 2'd1;
    localparam logic [1:0] PAL_NORMAL = 2'd2;
    localparam logic [1:0] PAL_BRIGHT = 2'd3;

    // Attribute codes and masks
    localparam logic [7:0] ATTR_VISIBLE_MASK  = 8'h77;
    localparam logic [7:0] ATTR_REV           = 8'h70;
    localparam logic [7:0] ATTR_REV_FG_DIM    = 8'h78;
    localparam logic [7:0] ATTR_REV_BG_BRIGHT = 8'hF0;
    localparam logic [7:0] ATTR_REV_BOTH      = 8'hF8;
    localparam logic [2:0] ATTR_UNDERLINE     = 3'b001;

    // Line-drawing codes 0xC0-0xDF repeat the eighth pixel
    localparam logic [2:0] CHAR_LINE_TOP = 3'b110;

    localparam logic [4:0] COUNT_TEXT8  = 5'd8;
    localparam logic [4:0] COUNT_TEXT9  = 5'd9;
    localparam logic [4:0] COUNT_GRAPH  = 5'd16;

    // Cell captured at the input, with mode and frame bits snapped
    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [7:0] glyph_bits;
        logic [7:0] second_byte;
        logic       cursor_here;
        logic [1:0] mode;
        logic       nine;
        logic       cursor_phase;  // frame bit 3
        logic       blink_phase;   // frame bit 4
    } cell_t;

    // Decoded cell: sixteen pattern bits plus colours
    typedef struct packed {
        logic [15:0] bits;
        logic [1:0]  fg;
        logic [1:0]  bg;
        logic        graphics;
        logic        nine;
        logic        ninth_on;
    } paint_t;

endpackage

// File: rtl/core/mtar_cell_if.sv
interface mtar_cell_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] glyph_bits;
    logic [7:0] second_byte;
    logic       cursor_here;

    modport source (output valid, kind, char_code, attribute, glyph_bits, second_byte,
                    cursor_here, input ready);
    modport sink   (input valid, kind, char_code, attribute, glyph_bits, second_byte,
                    cursor_here, output ready);
endinterface

// File: rtl/core/mtar_pix_if.sv
interface mtar_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_indices;
    logic [4:0]  pixel_count;

    modport source (output valid, pixel_indices, pixel_count, input ready);
    modport sink   (input valid, pixel_indices, pixel_count, output ready);
endinterface

// File: rtl/core/mtar_attr_stage.sv
// Stage 2: attribute decode, produces pattern bits and colours.
module mtar_attr_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mtar_pkg::cell_t     cell_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mtar_pkg::paint_t    paint
);

    logic             valid_reg;
    mtar_pkg::paint_t paint_reg;
    mtar_pkg::paint_t paint_next;
    logic [7:0]       data;
    logic [1:0]       fg;
    logic [1:0]       bg;
    logic             underline;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign paint     = paint_reg;
    assign underline = (cell_data.attribute[2:0] == mtar_pkg::ATTR_UNDERLINE);

    always_comb
    begin
        fg   = cell_data.attribute[3] ? mtar_pkg::PAL_BRIGHT : mtar_pkg::PAL_NORMAL;
        bg   = mtar_pkg::PAL_BLACK;
        data = cell_data.glyph_bits;
        if ((cell_data.attribute & mtar_pkg::ATTR_VISIBLE_MASK) == 8'h00)
        begin
            data = 8'h00;
        end

        if (cell_data.mode == mtar_pkg::MODE_INTENSE)
        begin
            unique case (cell_data.attribute)
                mtar_pkg::ATTR_REV:
                begin
                    bg = mtar_pkg::PAL_NORMAL;
                    fg = mtar_pkg::PAL_BLACK;
                end
                mtar_pkg::ATTR_REV_FG_DIM:
                begin
                    bg = mtar_pkg::PAL_NORMAL;
                    fg = mtar_pkg::PAL_DIM;
                end
                mtar_pkg::ATTR_REV_BG_BRIGHT:
                begin
                    bg = mtar_pkg::PAL_BRIGHT;
                    fg = mtar_pkg::PAL_BLACK;
                end
                mtar_pkg::ATTR_REV_BOTH:
                begin
                    bg = mtar_pkg::PAL_BRIGHT;
                    fg = mtar_pkg::PAL_DIM;
                end
                default:
                begin
                end
            endcase
            if ((cell_data.cursor_here && cell_data.cursor_phase) || underline)
            begin
                data = 8'hFF;
            end
        end
        else
        begin
            unique case (cell_data.attribute)
                mtar_pkg::ATTR_REV, mtar_pkg::ATTR_REV_BG_BRIGHT:
                begin
                    bg = mtar_pkg::PAL_NORMAL;
                    fg = mtar_pkg::PAL_BLACK;
                end
                mtar_pkg::ATTR_REV_FG_DIM, mtar_pkg::ATTR_REV_BOTH:
                begin
                    bg = mtar_pkg::PAL_NORMAL;
                    fg = mtar_pkg::PAL_DIM;
                end
                default:
                begin
                end
            endcase
            if (underline)
            begin
                data = 8'hFF;
            end
            if (cell_data.cursor_here)
            begin
                if (cell_data.cursor_phase)
                begin
                    data = 8'hFF;
                end
            end
            else if (cell_data.attribute[7] && cell_data.blink_phase)
            begin
                data = 8'h00;
            end
        end

        paint_next.nine = cell_data.nine;
        if (cell_data.mode == mtar_pkg::MODE_GRAPHICS)
        begin
            paint_next.bits     = {cell_data.glyph_bits, cell_data.second_byte};
            paint_next.fg       = mtar_pkg::PAL_NORMAL;
            paint_next.bg       = mtar_pkg::PAL_BLACK;
            paint_next.graphics = 1'b1;
            paint_next.ninth_on = 1'b0;
        end
        else
        begin
            paint_next.bits     = {data, 8'h00};
            paint_next.fg       = fg;
            paint_next.bg       = bg;
            paint_next.graphics = 1'b0;
            paint_next.ninth_on = (cell_data.char_code[7:5] == mtar_pkg::CHAR_LINE_TOP)
                                  && data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            paint_reg <= paint_next;
        end
    end

endmodule

// File: rtl/core/mtar_pixel_stage.sv
// Stage 3: expands pattern bits into packed palette indices.
module mtar_pixel_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mtar_pkg::paint_t paint,
    mtar_pix_if.source       pixels
);

    logic        valid_reg;
    logic [31:0] indices_reg;
    logic [31:0] indices_next;
    logic [4:0]  count_reg;
    logic [4:0]  count_next;

    assign in_ready             = !valid_reg || pixels.ready;
    assign pixels.valid         = valid_reg;
    assign pixels.pixel_indices = indices_reg;
    assign pixels.pixel_count   = count_reg;

    always_comb
    begin
        indices_next = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (paint.graphics || k < 8)
            begin
                indices_next[31-2*k -: 2] = paint.bits[15-k] ? paint.fg : paint.bg;
            end
        end
        if (paint.graphics)
        begin
            count_next = mtar_pkg::COUNT_GRAPH;
        end
        else if (paint.nine)
        begin
            indices_next[15:14] = paint.ninth_on ? paint.fg : paint.bg;
            count_next = mtar_pkg::COUNT_TEXT9;
        end
        else
        begin
            count_next = mtar_pkg::COUNT_TEXT8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            indices_reg <= indices_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: rtl/core/mono_text_attribute_renderer.sv
// Monochrome text cell renderer. Takes one item per cycle on cells while pixels
// is not stalled, and gives one row of 2-bit palette indices per drawn cell on
// pixels, first pixel in bits 31:30, unused bits zero. Three register stages
// (capture, attribute decode, pixel expansion) hold each cell in turn before its
// result is presented on pixels. Each stage takes a new item in the same cycle
// that its current one moves on, and only holds while its successor is full and
// stalled, so a stall on pixels backs up through the pipe without loss.
// A vertical-sync item (kind 1) advances the 5-bit frame counter when accepted
// and yields no result; cells accepted while the display is off yield none
// either. The frame counter's bit 3 blinks the cursor and bit 4 blinks text; the
// value sampled is the one current when the cell is accepted. Registers:
// index 0 display_mode (0 off, 1 text with intense background, 2 text with
// blinking, 3 two-byte graphics), index 1 nine_dot_cells. Write them only while
// the pipe is empty.
module mono_text_attribute_renderer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mtar_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mtar_pkg::CFG_DATA_W-1:0]       cfg_data,
    mtar_cell_if.sink                             cells,
    mtar_pix_if.source                            pixels
);

    // configuration and frame state
    logic [1:0]       display_mode_reg;
    logic             nine_dot_reg;
    logic [4:0]       frame_count_reg;

    // stage 1: capture
    logic             s1_valid_reg;
    mtar_pkg::cell_t  s1_cell_reg;
    mtar_pkg::cell_t  s1_cell_next;
    logic             s1_ready;
    logic             s1_take;

    // stage 2 -> stage 3
    logic             s2_valid;
    logic             s2_ready;
    mtar_pkg::paint_t s2_paint;

    logic             accept;

    assign cells.ready = !s1_valid_reg || s1_ready;
    assign accept      = cells.valid && cells.ready;
    // only drawn cells enter the pipe
    assign s1_take     = accept && (cells.kind == mtar_pkg::KIND_CELL)
                         && (display_mode_reg != mtar_pkg::MODE_OFF);

    always_comb
    begin
        s1_cell_next.char_code    = cells.char_code;
        s1_cell_next.attribute    = cells.attribute;
        s1_cell_next.glyph_bits   = cells.glyph_bits;
        s1_cell_next.second_byte  = cells.second_byte;
        s1_cell_next.cursor_here  = cells.cursor_here;
        s1_cell_next.mode         = display_mode_reg;
        s1_cell_next.nine         = nine_dot_reg;
        s1_cell_next.cursor_phase = frame_count_reg[3];
        s1_cell_next.blink_phase  = frame_count_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg <= mtar_pkg::MODE_OFF;
            nine_dot_reg     <= 1'b1;
            frame_count_reg  <= 5'd0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mtar_pkg::REG_DISPLAY_MODE: display_mode_reg <= cfg_data[1:0];
                    mtar_pkg::REG_NINE_DOT:     nine_dot_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept && (cells.kind == mtar_pkg::KIND_VSYNC))
            begin
                frame_count_reg <= frame_count_reg + 5'd1;
            end
            if (cells.ready)
            begin
                s1_valid_reg <= s1_take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_cell_reg <= s1_cell_next;
        end
    end

    mtar_attr_stage u_attr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (s1_ready),
        .cell_data (s1_cell_reg),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .paint     (s2_paint)
    );

    mtar_pixel_stage u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .paint    (s2_paint),
        .pixels   (pixels)
    );

    // A result carries one of the three legal pixel counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid |-> (pixels.pixel_count == mtar_pkg::COUNT_TEXT8
                       || pixels.pixel_count == mtar_pkg::COUNT_TEXT9
                       || pixels.pixel_count == mtar_pkg::COUNT_GRAPH))
        else $error("illegal pixel count");

    // Text rows leave everything past the ninth pixel clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.pixel_count != mtar_pkg::COUNT_GRAPH)
            |-> (pixels.pixel_indices[13:0] == 14'd0))
        else $error("text row has stray pixels");

    // A vsync item advances the frame counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cells.kind == mtar_pkg::KIND_VSYNC)
            |=> (frame_count_reg == $past(frame_count_reg) + 5'd1))
        else $error("frame counter did not advance");

    // Nothing enters the pipe from a vsync item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cells.kind == mtar_pkg::KIND_VSYNC) |=> !s1_valid_reg)
        else $error("vsync item entered the pipe");

endmodule
